/* rtl/drf_pkg.sv */
// Shared constants and types for the dense rank factorizer.
package drf_pkg;

   localparam int unsigned MAX_ITEMS_DEF = 32;
   localparam int unsigned KEY_BITS_DEF  = 64;

   localparam int unsigned IN_KEY_W   = 64;
   localparam int unsigned OUT_POS_W  = 5;
   localparam int unsigned OUT_CODE_W = 6;
   localparam int unsigned OUT_VAL_W  = 64;

   // Result kinds
   localparam logic KIND_CODE = 1'b0;
   localparam logic KIND_KEY  = 1'b1;

   // Per-cycle command broadcast along the sort chain
   typedef struct packed {
      logic insert;
      logic shift;
   } chain_ctrl_type;

endpackage

/* rtl/drf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module drf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/drf_cell.sv */
// One cell of the insertion-sort chain: holds a key and its arrival position.
module drf_cell import drf_pkg::*; #(
   parameter int unsigned KEY_BITS = KEY_BITS_DEF,
   parameter int unsigned POS_W    = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  chain_ctrl_type      ctrl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [POS_W-1:0]    new_pos,
   // left neighbour (lower, smaller keys)
   input  logic                left_valid,
   input  logic                left_gt,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [POS_W-1:0]    left_pos,
   // right neighbour (higher)
   input  logic                right_valid,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [POS_W-1:0]    right_pos,
   output logic                valid,
   output logic                gt,
   output logic [KEY_BITS-1:0] key,
   output logic [POS_W-1:0]    pos
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   // strictly greater keeps equal keys in arrival order
   assign gt = valid_ff && (key_ff > new_key);

   always_comb begin
      priority if (ctrl.shift) begin
         valid_in = right_valid;
         key_in   = right_key;
         pos_in   = right_pos;
      end else if (ctrl.insert && left_gt) begin
         valid_in = left_valid;
         key_in   = left_key;
         pos_in   = left_pos;
      end else if (ctrl.insert && (gt || (!valid_ff && left_valid))) begin
         valid_in = 1'b1;
         key_in   = new_key;
         pos_in   = new_pos;
      end else begin
         valid_in = valid_ff;
         key_in   = key_ff;
         pos_in   = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign pos   = pos_ff;

endmodule

/* rtl/dense_rank_factorizer.sv */
// Top level of the dense rank factorizer: sort chain, code stores and sequencer.
//
// Usage. Keys are loaded one word per accepted command (start high while busy
// low), each key inserted in a chain of MAX_ITEMS cells as it is accepted. A
// key with req_last high closes the set; keys beyond MAX_ITEMS are dropped and
// rsp_overflow is set on every result. After the closing key busy rises. The
// chain is then shifted out through its head, writing each key's dense code
// into a code store indexed by arrival position and each distinct key into a
// key store. Next the code store is read in arrival order (n results for n
// stored keys, kind 0), then the key store (d results for d distinct keys,
// kind 1, the last with rsp_final_res). One result word a cycle. Results are
// strobed by rsp_valid for one cycle each; the receiver cannot stall. busy
// falls with the final result, and a new set may start in that same cycle.
// Reset empties the chain and clears the key count and overflow flag.
module dense_rank_factorizer import drf_pkg::*; #(
   parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int unsigned KEY_BITS  = KEY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [IN_KEY_W-1:0]   req_key,
   input  logic                  req_last,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [OUT_POS_W-1:0]  rsp_position,
   output logic [OUT_CODE_W-1:0] rsp_code,
   output logic [OUT_VAL_W-1:0]  rsp_value,
   output logic                  rsp_overflow,
   output logic                  rsp_final_res
);

   localparam int unsigned PW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned RW = CW + KEY_BITS;

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_CODES, ST_KEYS} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] code_ff, code_in;
   logic [CW-1:0] dist_ff, dist_in;
   logic [KEY_BITS-1:0] prev_key_ff, prev_key_in;
   // read pipeline stage
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_kind_ff, rd_kind_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_fin_ff, rd_fin_in;
   logic          rd_ovf_ff, rd_ovf_in;

   chain_ctrl_type      ctrl;
   logic [KEY_BITS-1:0] new_key;
   logic                cell_valid [MAX_ITEMS];
   logic                cell_gt    [MAX_ITEMS];
   logic [KEY_BITS-1:0] cell_key   [MAX_ITEMS];
   logic [PW-1:0]       cell_pos   [MAX_ITEMS];

   logic                accept;
   logic                new_dist;
   logic [CW-1:0]       code_new;
   logic                pos_rd_en, dist_rd_en, dist_wr_en;
   logic [PW-1:0]       rd_addr;
   logic [RW-1:0]       pos_rd_data;
   logic [KEY_BITS-1:0] dist_rd_data;

   assign new_key = req_key[KEY_BITS-1:0];
   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_LOAD);

   // Sort chain
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                lv, lg, rv;
      logic [KEY_BITS-1:0] lk, rk;
      logic [PW-1:0]       lp, rp;
      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign lg = 1'b0;
         assign lk = '0;
         assign lp = '0;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign lg = cell_gt[i-1];
         assign lk = cell_key[i-1];
         assign lp = cell_pos[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign rv = 1'b0;
         assign rk = '0;
         assign rp = '0;
      end else begin : g_body
         assign rv = cell_valid[i+1];
         assign rk = cell_key[i+1];
         assign rp = cell_pos[i+1];
      end
      drf_cell #(.KEY_BITS(KEY_BITS), .POS_W(PW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_key     (new_key),
         .new_pos     (PW'(count_ff)),
         .left_valid  (lv),
         .left_gt     (lg),
         .left_key    (lk),
         .left_pos    (lp),
         .right_valid (rv),
         .right_key   (rk),
         .right_pos   (rp),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i]),
         .key         (cell_key[i]),
         .pos         (cell_pos[i])
      );
   end

   // Dense code of the head key during the scan
   assign new_dist = (idx_ff == '0) || (cell_key[0] != prev_key_ff);
   assign code_new = new_dist ? (code_ff + CW'(1)) : code_ff;
   assign dist_wr_en = (state_ff == ST_SCAN) && new_dist;

   // Code and key stores
   drf_ram #(.WIDTH(RW), .DEPTH(MAX_ITEMS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_SCAN),
      .wr_addr (cell_pos[0]),
      .wr_data ({code_new, cell_key[0]}),
      .rd_en   (pos_rd_en),
      .rd_addr (rd_addr),
      .rd_data (pos_rd_data)
   );

   drf_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ITEMS)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (PW'(code_new - CW'(1))),
      .wr_data (cell_key[0]),
      .rd_en   (dist_rd_en),
      .rd_addr (rd_addr),
      .rd_data (dist_rd_data)
   );

   assign rd_addr = PW'(idx_ff);

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      idx_in      = idx_ff;
      code_in     = code_ff;
      dist_in     = dist_ff;
      prev_key_in = prev_key_ff;
      rd_vld_in   = 1'b0;
      rd_kind_in  = rd_kind_ff;
      rd_idx_in   = rd_idx_ff;
      rd_fin_in   = 1'b0;
      rd_ovf_in   = rd_ovf_ff;
      ctrl        = '0;
      pos_rd_en   = 1'b0;
      dist_rd_en  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
                  code_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            ctrl.shift  = 1'b1;
            code_in     = code_new;
            prev_key_in = cell_key[0];
            if (idx_ff == count_ff - CW'(1)) begin
               dist_in  = code_new;
               idx_in   = '0;
               state_in = ST_CODES;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_CODES: begin
            pos_rd_en  = 1'b1;
            rd_vld_in  = 1'b1;
            rd_kind_in = KIND_CODE;
            rd_idx_in  = idx_ff;
            rd_ovf_in  = ovf_ff;
            if (idx_ff == count_ff - CW'(1)) begin
               idx_in   = '0;
               state_in = ST_KEYS;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_KEYS: begin
            dist_rd_en = 1'b1;
            rd_vld_in  = 1'b1;
            rd_kind_in = KIND_KEY;
            rd_idx_in  = idx_ff;
            rd_ovf_in  = ovf_ff;
            if (idx_ff == dist_ff - CW'(1)) begin
               rd_fin_in = 1'b1;
               idx_in    = '0;
               count_in  = '0;
               ovf_in    = 1'b0;
               state_in  = ST_LOAD;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         idx_ff    <= '0;
         code_ff   <= '0;
         dist_ff   <= '0;
         rd_vld_ff <= 1'b0;
         rd_fin_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         idx_ff    <= idx_in;
         code_ff   <= code_in;
         dist_ff   <= dist_in;
         rd_vld_ff <= rd_vld_in;
         rd_fin_ff <= rd_fin_in;
      end
      prev_key_ff <= prev_key_in;
      rd_kind_ff  <= rd_kind_in;
      rd_idx_ff   <= rd_idx_in;
      rd_ovf_ff   <= rd_ovf_in;
   end

   // Result word
   assign rsp_valid     = rd_vld_ff;
   assign rsp_kind      = rd_kind_ff;
   assign rsp_position  = OUT_POS_W'(rd_idx_ff);
   assign rsp_code      = (rd_kind_ff == KIND_KEY) ? OUT_CODE_W'(rd_idx_ff + CW'(1))
                                                   : OUT_CODE_W'(pos_rd_data[RW-1:KEY_BITS]);
   assign rsp_value     = (rd_kind_ff == KIND_KEY) ? OUT_VAL_W'(dist_rd_data)
                                                   : OUT_VAL_W'(pos_rd_data[KEY_BITS-1:0]);
   assign rsp_overflow  = rd_ovf_ff;
   assign rsp_final_res = rd_vld_ff && rd_fin_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("key count above capacity");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> cell_valid[0])
      else $error("scan reached an empty chain head");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_final_res |-> !busy && (count_ff == '0 || $past(accept)))
      else $error("final result while still busy");

   a_chain_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CODES) || (state_ff == ST_KEYS)) |-> !cell_valid[0])
      else $error("chain not emptied after scan");

endmodule
